/* hw/rtl/ncmp_pkg.sv */
package ncmp_pkg;

  localparam int VALUE_W = 64;
  localparam int UNIT_W = 16;
  localparam int TOKEN_W = VALUE_W + 1;

  localparam logic [1:0] OP_LOAD_FIRST = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPARE = 2'd2;

  localparam logic [UNIT_W-1:0] DIGIT_ZERO = 16'h0030;
  localparam logic [UNIT_W-1:0] DIGIT_NINE = 16'h0039;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_NUM = 1'b1;

  typedef struct packed {
    logic [1:0]        op;
    logic [UNIT_W-1:0] code_unit;
  } req_t;

  typedef struct packed {
    logic first_before;
    logic truncated;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic rd;
    logic take_cmp;
    logic take_len;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic differ;
  } dp_status_t;

endpackage

/* hw/rtl/ncmp_ram.sv */
module ncmp_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/ncmp_list.sv */
module ncmp_list #(
  parameter int MAX_TOKENS = 256,
  localparam int AW = $clog2(MAX_TOKENS),
  localparam int CW = $clog2(MAX_TOKENS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [ncmp_pkg::UNIT_W-1:0]  unit,
  input  logic                         clear,
  input  logic [AW-1:0]                raddr,
  output logic [ncmp_pkg::TOKEN_W-1:0] rdata,
  output logic [CW-1:0]                count,
  output logic                         cut_set
);

  logic                         cut;
  logic                         last_kind;
  logic [ncmp_pkg::VALUE_W-1:0] last_value;
  logic                         digit;
  logic [3:0]                   dval;
  logic                         extend;
  logic                         full;
  logic                         do_load;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [CW-1:0]                count_dec;
  logic [ncmp_pkg::VALUE_W-1:0] ext_value;
  logic [ncmp_pkg::VALUE_W-1:0] new_value;
  logic                         new_kind;

  always_comb begin
    digit = (unit >= ncmp_pkg::DIGIT_ZERO) && (unit <= ncmp_pkg::DIGIT_NINE);
    dval = unit[3:0];
    extend = digit && (count != '0) && (last_kind == ncmp_pkg::KIND_NUM);
    full = (count == CW'(MAX_TOKENS));
    do_load = load && !cut;
    count_dec = count - CW'(1);
    ext_value = {last_value[ncmp_pkg::VALUE_W-4:0], 3'b000}
              + {last_value[ncmp_pkg::VALUE_W-2:0], 1'b0}
              + {{(ncmp_pkg::VALUE_W-4){1'b0}}, dval};
    if (extend) begin
      new_kind = ncmp_pkg::KIND_NUM;
      new_value = ext_value;
      waddr = count_dec[AW-1:0];
    end else begin
      new_kind = digit ? ncmp_pkg::KIND_NUM : ncmp_pkg::KIND_CHAR;
      new_value = digit ? {{(ncmp_pkg::VALUE_W-4){1'b0}}, dval}
                        : {{(ncmp_pkg::VALUE_W-ncmp_pkg::UNIT_W){1'b0}}, unit};
      waddr = count[AW-1:0];
    end
    we = do_load && (extend || !full);
    cut_set = do_load && !extend && full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cut <= 1'b0;
    end else if (clear) begin
      count <= '0;
      cut <= 1'b0;
    end else if (do_load && !extend) begin
      if (full) begin
        cut <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      last_kind <= new_kind;
      last_value <= new_value;
    end
  end

  ncmp_ram #(
    .WIDTH(ncmp_pkg::TOKEN_W),
    .DEPTH(MAX_TOKENS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({new_kind, new_value}),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

/* hw/rtl/ncmp_datapath.sv */
module ncmp_datapath #(
  parameter int MAX_TOKENS = 256,
  localparam int AW = $clog2(MAX_TOKENS),
  localparam int CW = $clog2(MAX_TOKENS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ncmp_pkg::req_t         req,
  input  ncmp_pkg::ctrl_cmd_t    cmd,
  output ncmp_pkg::dp_status_t   status,
  output ncmp_pkg::rsp_t         rsp
);

  logic [ncmp_pkg::TOKEN_W-1:0] first_tok;
  logic [ncmp_pkg::TOKEN_W-1:0] second_tok;
  logic [CW-1:0]                first_count;
  logic [CW-1:0]                second_count;
  logic                         first_cut_set;
  logic                         second_cut_set;
  logic                         overflow_seen;
  logic [CW-1:0]                idx;
  logic [CW-1:0]                walk_len;
  logic                         kinds_differ;
  logic                         tok_less;
  logic                         res;

  ncmp_list #(.MAX_TOKENS(MAX_TOKENS)) u_first (
    .clk    (clk),
    .rst    (rst),
    .load   (cmd.load_first),
    .unit   (req.code_unit),
    .clear  (cmd.emit),
    .raddr  (idx[AW-1:0]),
    .rdata  (first_tok),
    .count  (first_count),
    .cut_set(first_cut_set)
  );

  ncmp_list #(.MAX_TOKENS(MAX_TOKENS)) u_second (
    .clk    (clk),
    .rst    (rst),
    .load   (cmd.load_second),
    .unit   (req.code_unit),
    .clear  (cmd.emit),
    .raddr  (idx[AW-1:0]),
    .rdata  (second_tok),
    .count  (second_count),
    .cut_set(second_cut_set)
  );

  always_comb begin
    walk_len = (first_count < second_count) ? first_count : second_count;
    kinds_differ = first_tok[ncmp_pkg::TOKEN_W-1] != second_tok[ncmp_pkg::TOKEN_W-1];
    if (kinds_differ) begin
      tok_less = first_tok[ncmp_pkg::TOKEN_W-1] == ncmp_pkg::KIND_NUM;
    end else begin
      tok_less = first_tok[ncmp_pkg::VALUE_W-1:0] < second_tok[ncmp_pkg::VALUE_W-1:0];
    end
    status.walk_done = (idx == walk_len);
    status.differ = kinds_differ
                 || (first_tok[ncmp_pkg::VALUE_W-1:0] != second_tok[ncmp_pkg::VALUE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.emit) begin
      idx <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.rd) begin
        idx <= idx + CW'(1);
      end
      if (first_cut_set || second_cut_set) begin
        overflow_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_cmp) begin
      res <= tok_less;
    end else if (cmd.take_len) begin
      res <= first_count < second_count;
    end
    if (cmd.emit) begin
      rsp.first_before <= res;
      rsp.truncated <= overflow_seen;
    end
  end

endmodule

/* hw/rtl/ncmp_ctrl.sv */
module ncmp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic [1:0]           op,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  ncmp_pkg::dp_status_t status,
  output ncmp_pkg::ctrl_cmd_t  cmd
);

  ncmp_pkg::state_t state;
  ncmp_pkg::state_t state_next;
  logic             rsp_valid_next;
  logic             accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ncmp_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    req_stall = (state != ncmp_pkg::ST_IDLE);
    accept = req_valid && !req_stall;
    case (state)
      ncmp_pkg::ST_IDLE: begin
        cmd.load_first = accept && (op == ncmp_pkg::OP_LOAD_FIRST);
        cmd.load_second = accept && (op == ncmp_pkg::OP_LOAD_SECOND);
        if (accept && (op == ncmp_pkg::OP_COMPARE)) begin
          if (status.walk_done) begin
            cmd.take_len = 1'b1;
            state_next = ncmp_pkg::ST_FINISH;
          end else begin
            state_next = ncmp_pkg::ST_READ;
          end
        end
      end
      ncmp_pkg::ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ncmp_pkg::ST_CHECK;
      end
      ncmp_pkg::ST_CHECK: begin
        if (status.differ) begin
          cmd.take_cmp = 1'b1;
          state_next = ncmp_pkg::ST_FINISH;
        end else if (status.walk_done) begin
          cmd.take_len = 1'b1;
          state_next = ncmp_pkg::ST_FINISH;
        end else begin
          state_next = ncmp_pkg::ST_READ;
        end
      end
      ncmp_pkg::ST_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.emit = 1'b1;
          state_next = ncmp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ncmp_pkg::ST_IDLE;
      end
    endcase
    rsp_valid_next = cmd.emit || (rsp_valid && rsp_stall);
  end

endmodule

/* hw/rtl/natural_order_name_compare_unit.sv */
// Load items are taken one per cycle while the unit is idle; each updates its token RAM in that cycle.
// A compare item holds off new items while it walks the token pairs: a read and a check
// state per pair, until a pair differs or the shorter list ends, then a finish state to emit.
// The result is registered at the emit and is held while stalled; an earlier result still
// stalled delays the emit.
// Reset is synchronous and clears counts, flags, state and result valid, not the RAMs.
module natural_order_name_compare_unit #(
  parameter int MAX_TOKENS = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ncmp_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ncmp_pkg::rsp_t  rsp
);

  ncmp_pkg::ctrl_cmd_t  cmd;
  ncmp_pkg::dp_status_t status;

  ncmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .op       (req.op),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ncmp_datapath #(.MAX_TOKENS(MAX_TOKENS)) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .cmd   (cmd),
    .status(status),
    .rsp   (rsp)
  );

endmodule

/* hw/rtl/ncmp_checker.sv */
module ncmp_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input ncmp_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input ncmp_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result item changed or dropped");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_compare_holds_off: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.op == ncmp_pkg::OP_COMPARE) |=> req_stall)
    else $error("compare item did not hold off input");

  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall
    && ((req.op == ncmp_pkg::OP_LOAD_FIRST) || (req.op == ncmp_pkg::OP_LOAD_SECOND))
    |=> !req_stall)
    else $error("load item caused a stall");

  a_result_after_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result item without a compare walk");

endmodule

bind natural_order_name_compare_unit ncmp_checker u_checker (.*);
